FILE: hw/rtl/per_server_moving_average_overload_macros.svh
// Assertion helpers used by the top level to check the design.
`ifndef PER_SERVER_MOVING_AVERAGE_OVERLOAD_MACROS_SVH
`define PER_SERVER_MOVING_AVERAGE_OVERLOAD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSMAO_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define PSMAO_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

FILE: hw/rtl/psmao_pkg.sv
`timescale 1ns / 1ps
package psmao_pkg;

	// Sizing of the per-server store and the sample window.
	localparam int SERVERS    = 16;
	localparam int WINDOW_MAX = 16;

	// Field widths fixed by the record and result formats.
	localparam int SID_W  = 4;
	localparam int TS_W   = 47;
	localparam int PING_W = 16;
	localparam int WIN_W  = 5;
	localparam int THR_W  = 16;

	localparam logic [WIN_W-1:0] WIN_RESET = 5'd16;
	localparam logic [THR_W-1:0] THR_RESET = 16'd1000;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef enum logic {
		REG_WINDOW    = 1'b0,
		REG_THRESHOLD = 1'b1
	} reg_sel_t;

	// Derived widths.
	localparam int SRV_AW     = (SERVERS > 1) ? $clog2(SERVERS) : 1;
	localparam int WIN_AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int HELD_W     = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W      = $clog2(WINDOW_MAX * ((1 << PING_W) - 1) + 1);
	localparam int LIM_W      = THR_W + HELD_W;
	localparam int RING_DEPTH = SERVERS * WINDOW_MAX;
	localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	// Result queue that decouples the pipeline from the consumer.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// One entry of the per-server state memory.
	typedef struct packed {
		logic [WIN_AW-1:0] head;
		logic [HELD_W-1:0] held;
		logic [SUM_W-1:0]  sum;
		logic              overloaded;
		logic [TS_W-1:0]   start;
	} state_t;

	typedef struct packed {
		logic [SID_W-1:0] server_id;
		logic [TS_W-1:0]  start;
		logic [TS_W-1:0]  recovery;
	} result_t;

	// Pipeline status seen by the top level.
	typedef struct packed {
		logic clearing;
		logic v_s1;
		logic v_s2;
	} core_stat_t;

	function automatic logic srv_in_range(input logic [SID_W-1:0] sid);
		return 32'(sid) < 32'(SERVERS);
	endfunction

	function automatic logic [SRV_AW-1:0] srv_idx(input logic [SID_W-1:0] sid);
		logic [SID_W+SRV_AW-1:0] ext;
		ext = {{SRV_AW{1'b0}}, sid};
		return ext[SRV_AW-1:0];
	endfunction

	function automatic logic [RING_AW-1:0] ring_addr(input logic [SRV_AW-1:0] idx,
		input logic [WIN_AW-1:0] slot);
		return RING_AW'(idx) * RING_AW'(WINDOW_MAX) + RING_AW'(slot);
	endfunction

endpackage

FILE: hw/rtl/psmao_in_if.sv
`timescale 1ns / 1ps
interface psmao_in_if;
	logic                         valid;
	logic                         ready;
	logic [psmao_pkg::SID_W-1:0]  server_id;
	logic [psmao_pkg::TS_W-1:0]   timestamp;
	logic [psmao_pkg::PING_W-1:0] ping_ms;
	logic                         timed_out;

	modport source (output valid, server_id, timestamp, ping_ms, timed_out, input ready);
	modport sink (input valid, server_id, timestamp, ping_ms, timed_out, output ready);
endinterface

FILE: hw/rtl/psmao_out_if.sv
`timescale 1ns / 1ps
interface psmao_out_if;
	logic                        valid;
	logic                        ready;
	logic [psmao_pkg::SID_W-1:0] server_id_out;
	logic [psmao_pkg::TS_W-1:0]  overload_start;
	logic [psmao_pkg::TS_W-1:0]  recovery_time;

	modport source (output valid, server_id_out, overload_start, recovery_time, input ready);
	modport sink (input valid, server_id_out, overload_start, recovery_time, output ready);
endinterface

FILE: hw/rtl/psmao_ram.sv
`timescale 1ns / 1ps
module psmao_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle; a read of the entry being
	// written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/psmao_cfg.sv
`timescale 1ns / 1ps
module psmao_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [psmao_pkg::PADDR_W-1:0]   paddr,
	input  logic [psmao_pkg::PDATA_W-1:0]   pwdata,
	output logic [psmao_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	output logic [psmao_pkg::WIN_W-1:0]     window_length,
	output logic [psmao_pkg::THR_W-1:0]     threshold
);
	import psmao_pkg::*;

	logic [WIN_W-1:0] window_q;
	logic [THR_W-1:0] threshold_q;
	reg_sel_t         sel;
	logic             wr_en;

	// Registers sit on word boundaries, so the word index picks the register.
	assign sel    = reg_sel_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WIN_RESET;
			threshold_q <= THR_RESET;
		end else if (wr_en) begin
			unique case (sel)
				REG_WINDOW:    window_q    <= pwdata[WIN_W-1:0];
				REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back.
	always_comb begin
		unique case (sel)
			REG_WINDOW:    prdata = PDATA_W'(window_q);
			REG_THRESHOLD: prdata = PDATA_W'(threshold_q);
			default:       prdata = '0;
		endcase
	end

	assign window_length = window_q;
	assign threshold     = threshold_q;

endmodule

FILE: hw/rtl/psmao_core.sv
`timescale 1ns / 1ps
module psmao_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [psmao_pkg::SID_W-1:0]   server_id,
	input  logic [psmao_pkg::TS_W-1:0]    timestamp,
	input  logic [psmao_pkg::PING_W-1:0]  ping_ms,
	input  logic                          timed_out,
	input  logic [psmao_pkg::WIN_W-1:0]   window_length,
	input  logic [psmao_pkg::THR_W-1:0]   threshold,
	output logic                          res_valid,
	output psmao_pkg::result_t            res,
	output psmao_pkg::core_stat_t         stat
);
	import psmao_pkg::*;

	// Clearing pass over the state memory after reset.
	logic              clr_q;
	logic [SRV_AW-1:0] clr_cnt_q;

	// Stage 1: state read returns, ring slot chosen.
	logic              v_s1;
	logic [SID_W-1:0]  sid_s1;
	logic [TS_W-1:0]   ts_s1;
	logic [PING_W-1:0] ping_s1;

	// Stage 2: ring read returns, sum updated and compared.
	logic              v_s2;
	logic [SID_W-1:0]  sid_s2;
	logic [TS_W-1:0]   ts_s2;
	logic [PING_W-1:0] ping_s2;
	logic              evict_s2;
	logic [WIN_AW-1:0] head_s2;
	logic [HELD_W-1:0] held_s2;
	logic [LIM_W-1:0]  limit_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic              flag_s2;
	logic [TS_W-1:0]   start_s2;

	// Copy of the last entry written back, for forwarding.
	logic              wb_v_q;
	logic [SRV_AW-1:0] wb_idx_q;
	state_t            wb_st_q;

	logic [$bits(state_t)-1:0] st_rdata;
	logic [$bits(state_t)-1:0] st_wdata;
	logic                      st_we;
	logic [SRV_AW-1:0]         st_waddr;
	logic [PING_W-1:0]         ring_rdata;
	logic [RING_AW-1:0]        ring_waddr;
	logic [RING_AW-1:0]        ring_raddr;

	logic              keep_s0;
	logic [HELD_W-1:0] w_eff;
	state_t            st_m1;
	logic              evict_s1;
	logic [HELD_W-1:0] held_n;
	logic [WIN_AW-1:0] head_n;
	logic [HELD_W:0]   diff;
	logic [HELD_W:0]   oldest_w;
	logic [WIN_AW-1:0] oldest;
	logic [HELD_W-1:0] used;
	logic [LIM_W-1:0]  limit_n;

	logic [SUM_W-1:0]  sum_in;
	logic              flag_in;
	logic [TS_W-1:0]   start_in;
	logic [SUM_W-1:0]  sum_n;
	logic              over;
	logic              flag_n;
	logic [TS_W-1:0]   start_n;
	state_t            st_new;

	// Timed-out and out-of-range records leave no trace.
	assign keep_s0 = accept && !timed_out && srv_in_range(server_id);

	// Window length zero acts as one; above the maximum it is clamped.
	always_comb begin
		if (window_length == '0) begin
			w_eff = HELD_W'(1);
		end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
			w_eff = HELD_W'(WINDOW_MAX);
		end else begin
			w_eff = HELD_W'(window_length);
		end
	end

	psmao_ram #(
		.DEPTH(SERVERS),
		.WIDTH($bits(state_t))
	) u_state_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(srv_idx(server_id)),
		.rdata(st_rdata)
	);

	psmao_ram #(
		.DEPTH(RING_DEPTH),
		.WIDTH(PING_W)
	) u_ring_ram (
		.clk  (clk),
		.we   (v_s1),
		.waddr(ring_waddr),
		.wdata(ping_s1),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	// Stage 1 state: memory, then the last write-back, then the item in stage 2
	// whose head and count are already final.
	always_comb begin
		st_m1 = state_t'(st_rdata);
		if (wb_v_q && wb_idx_q == srv_idx(sid_s1)) begin
			st_m1 = wb_st_q;
		end
		if (v_s2 && sid_s2 == sid_s1) begin
			st_m1.head = head_s2;
			st_m1.held = held_s2;
		end
	end

	// Stage 1 window bookkeeping: eviction, new head, oldest slot, limit.
	always_comb begin
		evict_s1 = st_m1.held >= w_eff;
		held_n   = evict_s1 ? st_m1.held : st_m1.held + 1'b1;
		head_n   = (st_m1.head == WIN_AW'(WINDOW_MAX - 1)) ? '0 : st_m1.head + 1'b1;
		diff     = {1'b0, HELD_W'(st_m1.head)} - {1'b0, st_m1.held};
		oldest_w = diff[HELD_W] ? diff + (HELD_W + 1)'(WINDOW_MAX) : diff;
		oldest   = oldest_w[WIN_AW-1:0];
		used     = (held_n < w_eff) ? held_n : w_eff;
		limit_n  = LIM_W'(threshold) * LIM_W'(used);
	end

	assign ring_waddr = ring_addr(srv_idx(sid_s1), st_m1.head);
	assign ring_raddr = ring_addr(srv_idx(sid_s1), oldest);

	// Stage 2 forwarding of the entry written at the previous edge.
	always_comb begin
		sum_in   = sum_s2;
		flag_in  = flag_s2;
		start_in = start_s2;
		if (wb_v_q && wb_idx_q == srv_idx(sid_s2)) begin
			sum_in   = wb_st_q.sum;
			flag_in  = wb_st_q.overloaded;
			start_in = wb_st_q.start;
		end
	end

	// Stage 2 sum update and overload decision.
	always_comb begin
		sum_n   = sum_in - (evict_s2 ? SUM_W'(ring_rdata) : '0) + SUM_W'(ping_s2);
		over    = LIM_W'(sum_n) >= limit_s2;
		flag_n  = over;
		start_n = (over && !flag_in) ? ts_s2 : start_in;
		st_new  = '{head: head_s2, held: held_s2, sum: sum_n, overloaded: flag_n,
			start: start_n};
	end

	assign res_valid     = v_s2 && !over && flag_in;
	assign res.server_id = sid_s2;
	assign res.start     = start_in;
	assign res.recovery  = ts_s2;

	// Write-back port, shared with the clearing pass.
	assign st_we    = clr_q || v_s2;
	assign st_waddr = clr_q ? clr_cnt_q : srv_idx(sid_s2);
	assign st_wdata = clr_q ? '0 : st_new;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			wb_v_q    <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == SRV_AW'(SERVERS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			v_s1   <= keep_s0;
			v_s2   <= v_s1;
			wb_v_q <= v_s2;
		end
	end

	// Payload pipeline.
	always_ff @(posedge clk) begin
		sid_s1   <= server_id;
		ts_s1    <= timestamp;
		ping_s1  <= ping_ms;
		sid_s2   <= sid_s1;
		ts_s2    <= ts_s1;
		ping_s2  <= ping_s1;
		evict_s2 <= evict_s1;
		head_s2  <= head_n;
		held_s2  <= held_n;
		limit_s2 <= limit_n;
		sum_s2   <= st_m1.sum;
		flag_s2  <= st_m1.overloaded;
		start_s2 <= st_m1.start;
		wb_idx_q <= srv_idx(sid_s2);
		wb_st_q  <= st_new;
	end

	assign stat.clearing = clr_q;
	assign stat.v_s1     = v_s1;
	assign stat.v_s2     = v_s2;

endmodule

FILE: hw/rtl/psmao_outq.sv
`timescale 1ns / 1ps
module psmao_outq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  psmao_pkg::result_t         push_data,
	output logic [psmao_pkg::OQ_CW-1:0] count,
	psmao_out_if.source                recoveries
);
	import psmao_pkg::*;

	result_t          entries_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] count_q;
	logic             pop;

	assign pop = recoveries.valid && recoveries.ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	assign count                     = count_q;
	assign recoveries.valid          = count_q != '0;
	assign recoveries.server_id_out  = entries_q[rd_ptr_q].server_id;
	assign recoveries.overload_start = entries_q[rd_ptr_q].start;
	assign recoveries.recovery_time  = entries_q[rd_ptr_q].recovery;

endmodule

FILE: hw/rtl/per_server_moving_average_overload.sv
`timescale 1ns / 1ps
// A recovery result is decided in stage 2 and offered from the result queue.
// Throughput: one request per cycle while not clearing and the result queue has room;
// the state and ring memories are read, updated and written back in a two-stage
// pipeline with forwarding between same-server requests. Reset: asynchronous, active
// low; then a pass, one write per server, clears the state memory and blocks requests.
`include "per_server_moving_average_overload_macros.svh"
module per_server_moving_average_overload (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [psmao_pkg::PADDR_W-1:0]   paddr,
	input  logic [psmao_pkg::PDATA_W-1:0]   pwdata,
	output logic [psmao_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	psmao_in_if.sink                        records,
	psmao_out_if.source                     recoveries
);
	import psmao_pkg::*;

	logic [WIN_W-1:0] window_length;
	logic [THR_W-1:0] threshold;
	logic             accept;
	logic             res_valid;
	result_t          res;
	core_stat_t       stat;
	logic [OQ_CW-1:0] oq_count;
	logic [OQ_CW:0]   load;

	psmao_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.window_length(window_length),
		.threshold    (threshold)
	);

	// Every request in the pipeline holds a place in the result queue, so the
	// queue can never overflow.
	assign load = (OQ_CW + 1)'(oq_count) + (OQ_CW + 1)'(stat.v_s1)
		+ (OQ_CW + 1)'(stat.v_s2);
	assign records.ready = !stat.clearing && (load < (OQ_CW + 1)'(OQ_DEPTH));
	assign accept        = records.valid && records.ready;

	psmao_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.server_id    (records.server_id),
		.timestamp    (records.timestamp),
		.ping_ms      (records.ping_ms),
		.timed_out    (records.timed_out),
		.window_length(window_length),
		.threshold    (threshold),
		.res_valid    (res_valid),
		.res          (res),
		.stat         (stat)
	);

	psmao_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.count     (oq_count),
		.recoveries(recoveries)
	);

	// Checks.
	`PSMAO_ASSERT_IMPLIES(a_no_req_while_clearing, stat.clearing, !records.ready, "request taken during clearing pass")
	`PSMAO_ASSERT_NEVER(a_load_bound, load > (OQ_CW + 1)'(OQ_DEPTH), "queue reservations exceeded")
	`PSMAO_ASSERT_IMPLIES(a_push_has_room, res_valid, (oq_count < OQ_CW'(OQ_DEPTH)) || (recoveries.valid && recoveries.ready), "result pushed into a full queue")

endmodule
